// File: design/assert_macros.svh
// Concurrent check helpers, clocked on clk and held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a consequent holds in the cycle after its antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/rc4ms_pkg.sv
package rc4ms_pkg;

    // Default store depths
    localparam int KEY_MAX_DEF = 64;
    localparam int IV_MAX_DEF  = 64;

    // Field widths
    localparam int OP_W      = 2;
    localparam int INDEX_W   = 6;
    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int LEN_W     = 7;

    // Input op codes
    localparam logic [OP_W-1:0] OP_KEY  = 2'd0;
    localparam logic [OP_W-1:0] OP_IV   = 2'd1;
    localparam logic [OP_W-1:0] OP_DATA = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IV_LEN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROUNDS  = 2'd2;

    // Configuration reset values
    localparam logic [LEN_W-1:0]  KEY_LEN_RST = 7'd1;
    localparam logic [LEN_W-1:0]  IV_LEN_RST  = 7'd10;
    localparam logic [BYTE_W-1:0] ROUNDS_RST  = 8'd20;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_FILL,
        ST_SA,
        ST_SB,
        ST_SC,
        ST_SD,
        ST_SEND,
        ST_C1,
        ST_C2,
        ST_C3,
        ST_C4,
        ST_C5,
        ST_OUT
    } state_t;

    // Datapath commands
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_ACCEPT,
        CMD_INIT,
        CMD_FILL,
        CMD_SA,
        CMD_SB,
        CMD_SC,
        CMD_SD,
        CMD_SEND,
        CMD_C1,
        CMD_C2,
        CMD_C3,
        CMD_C4,
        CMD_C5,
        CMD_OUT
    } cmd_t;

    // Source of the expanded key byte during a schedule pass
    typedef enum logic [1:0] {
        PH_KEY,
        PH_IV,
        PH_REP
    } phase_t;

    // Datapath status seen by the controller
    typedef struct packed {
        logic done;
        logic p_last;
        logic round_last;
        logic rounds_zero;
        logic out_free;
    } sts_t;

endpackage

// File: design/rc4_multi_round_stream_cipher.sv
// Data byte with the schedule built: the controller steps through C1 to C5 and then OUT, where
// out_valid is registered; input stays stalled until the byte is loaded, so one byte at a time;
// each byte makes three dependent table reads and two writes, a stalled output holds it.
// First data byte after reset or a key or IV write builds the schedule first: an identity fill,
// then 256 schedule steps per round, each through SA to SD on the single-write table port.
// Reset clears the control state and loads register defaults (key 1, IV 10, rounds 20).
`include "assert_macros.svh"

module rc4_multi_round_stream_cipher #(
    parameter int KEY_MAX = rc4ms_pkg::KEY_MAX_DEF,
    parameter int IV_MAX  = rc4ms_pkg::IV_MAX_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [rc4ms_pkg::OP_W-1:0]        op,
    input  logic [rc4ms_pkg::INDEX_W-1:0]     index,
    input  logic [rc4ms_pkg::BYTE_W-1:0]      value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [rc4ms_pkg::BYTE_W-1:0]      out_byte,
    input  logic                              cfg_we,
    input  logic [rc4ms_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rc4ms_pkg::BYTE_W-1:0]      cfg_data
);

    rc4ms_pkg::cmd_t cmd;
    rc4ms_pkg::sts_t sts;

    rc4ms_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .op       (op),
        .sts      (sts),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    rc4ms_dp #(
        .KEY_MAX (KEY_MAX),
        .IV_MAX  (IV_MAX)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .op        (op),
        .index     (index),
        .value     (value),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_byte  (out_byte),
        .sts       (sts)
    );

    // A data beat holds off the input side while it is worked on
    `ASSERT_NEXT(a_data_busy, in_valid && !in_stall && op == rc4ms_pkg::OP_DATA, in_stall, "data beat did not hold off input")

    // A key or IV write leaves the schedule pending
    `ASSERT_NEXT(a_store_pending, in_valid && !in_stall && (op == rc4ms_pkg::OP_KEY || op == rc4ms_pkg::OP_IV), !sts.done, "store write did not mark schedule pending")

    // An output beat appears only from the output step
    `ASSERT_IMPLY(a_out_src, $rose(out_valid), $past(cmd == rc4ms_pkg::CMD_OUT), "output beat without output step")

    // The controller issues no work while idle waiting for input
    `ASSERT_ALWAYS(a_idle_cmd, in_stall || cmd == rc4ms_pkg::CMD_ACCEPT || cmd == rc4ms_pkg::CMD_NONE, "work command issued while idle")

endmodule

// File: design/rc4ms_ctrl.sv
module rc4ms_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [rc4ms_pkg::OP_W-1:0]   op,
    input  rc4ms_pkg::sts_t              sts,
    output logic                         in_stall,
    output rc4ms_pkg::cmd_t              cmd
);

    rc4ms_pkg::state_t state_reg;
    rc4ms_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rc4ms_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rc4ms_pkg::ST_IDLE:
            begin
                if (in_valid && op == rc4ms_pkg::OP_DATA)
                begin
                    state_next = sts.done ? rc4ms_pkg::ST_C1 : rc4ms_pkg::ST_INIT;
                end
            end
            rc4ms_pkg::ST_INIT: state_next = rc4ms_pkg::ST_FILL;
            rc4ms_pkg::ST_FILL:
            begin
                if (sts.p_last)
                begin
                    state_next = sts.rounds_zero ? rc4ms_pkg::ST_SEND : rc4ms_pkg::ST_SA;
                end
            end
            rc4ms_pkg::ST_SA: state_next = rc4ms_pkg::ST_SB;
            rc4ms_pkg::ST_SB: state_next = rc4ms_pkg::ST_SC;
            rc4ms_pkg::ST_SC: state_next = rc4ms_pkg::ST_SD;
            rc4ms_pkg::ST_SD:
            begin
                state_next = (sts.p_last && sts.round_last) ? rc4ms_pkg::ST_SEND
                                                            : rc4ms_pkg::ST_SA;
            end
            rc4ms_pkg::ST_SEND: state_next = rc4ms_pkg::ST_C1;
            rc4ms_pkg::ST_C1:   state_next = rc4ms_pkg::ST_C2;
            rc4ms_pkg::ST_C2:   state_next = rc4ms_pkg::ST_C3;
            rc4ms_pkg::ST_C3:   state_next = rc4ms_pkg::ST_C4;
            rc4ms_pkg::ST_C4:   state_next = rc4ms_pkg::ST_C5;
            rc4ms_pkg::ST_C5:   state_next = rc4ms_pkg::ST_OUT;
            rc4ms_pkg::ST_OUT:
            begin
                if (sts.out_free)
                begin
                    state_next = rc4ms_pkg::ST_IDLE;
                end
            end
            default: state_next = rc4ms_pkg::ST_IDLE;
        endcase
    end

    // Outputs: take beats only when idle, issue one command per state
    always_comb
    begin
        in_stall = (state_reg != rc4ms_pkg::ST_IDLE);
        cmd      = rc4ms_pkg::CMD_NONE;
        unique case (state_reg)
            rc4ms_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd = rc4ms_pkg::CMD_ACCEPT;
                end
            end
            rc4ms_pkg::ST_INIT: cmd = rc4ms_pkg::CMD_INIT;
            rc4ms_pkg::ST_FILL: cmd = rc4ms_pkg::CMD_FILL;
            rc4ms_pkg::ST_SA:   cmd = rc4ms_pkg::CMD_SA;
            rc4ms_pkg::ST_SB:   cmd = rc4ms_pkg::CMD_SB;
            rc4ms_pkg::ST_SC:   cmd = rc4ms_pkg::CMD_SC;
            rc4ms_pkg::ST_SD:   cmd = rc4ms_pkg::CMD_SD;
            rc4ms_pkg::ST_SEND: cmd = rc4ms_pkg::CMD_SEND;
            rc4ms_pkg::ST_C1:   cmd = rc4ms_pkg::CMD_C1;
            rc4ms_pkg::ST_C2:   cmd = rc4ms_pkg::CMD_C2;
            rc4ms_pkg::ST_C3:   cmd = rc4ms_pkg::CMD_C3;
            rc4ms_pkg::ST_C4:   cmd = rc4ms_pkg::CMD_C4;
            rc4ms_pkg::ST_C5:   cmd = rc4ms_pkg::CMD_C5;
            rc4ms_pkg::ST_OUT:  cmd = rc4ms_pkg::CMD_OUT;
            default:            cmd = rc4ms_pkg::CMD_NONE;
        endcase
    end

endmodule

// File: design/rc4ms_dp.sv
module rc4ms_dp #(
    parameter int KEY_MAX = rc4ms_pkg::KEY_MAX_DEF,
    parameter int IV_MAX  = rc4ms_pkg::IV_MAX_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rc4ms_pkg::cmd_t                   cmd,
    input  logic [rc4ms_pkg::OP_W-1:0]        op,
    input  logic [rc4ms_pkg::INDEX_W-1:0]     index,
    input  logic [rc4ms_pkg::BYTE_W-1:0]      value,
    input  logic                              cfg_we,
    input  logic [rc4ms_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rc4ms_pkg::BYTE_W-1:0]      cfg_data,
    input  logic                              out_stall,
    output logic                              out_valid,
    output logic [rc4ms_pkg::BYTE_W-1:0]      out_byte,
    output rc4ms_pkg::sts_t                   sts
);

    localparam int KEY_D = KEY_MAX;
    localparam int IV_D  = (IV_MAX > 0) ? IV_MAX : 1;
    localparam int KA_W  = (KEY_D > 1) ? $clog2(KEY_D) : 1;
    localparam int VA_W  = (IV_D > 1) ? $clog2(IV_D) : 1;
    localparam int TBL_D = 256;
    localparam logic [7:0] KEY_MAX_8 = 8'(KEY_MAX);
    localparam logic [7:0] IV_MAX_8  = 8'(IV_MAX);

    // Stores
    logic [7:0] perm_mem [TBL_D];
    logic [7:0] key_mem  [KEY_D];
    logic [7:0] iv_mem   [IV_D];

    // Configuration registers
    logic [rc4ms_pkg::LEN_W-1:0] key_len_reg;
    logic [rc4ms_pkg::LEN_W-1:0] iv_len_reg;
    logic [7:0]                  rounds_reg;

    // Control registers
    logic                  done_reg;
    logic [7:0]            p_reg;
    logic [7:0]            rnd_reg;
    logic [7:0]            i_reg;
    logic [7:0]            j_reg;
    logic [7:0]            q_reg;
    rc4ms_pkg::phase_t     phase_reg;
    logic                  esel_reg;
    logic                  out_valid_reg;

    // Payload registers
    logic [7:0] val_reg;
    logic [7:0] swap_a_reg;
    logic [7:0] swap_b_reg;
    logic [7:0] perm_rd_reg;
    logic [7:0] key_rd_reg;
    logic [7:0] iv_rd_reg;
    logic [7:0] out_byte_reg;

    // Next values and memory port controls
    logic [7:0]        q_next;
    rc4ms_pkg::phase_t phase_next;
    logic              mem_we;
    logic [7:0]        mem_waddr;
    logic [7:0]        mem_wdata;
    logic              mem_re;
    logic [7:0]        mem_raddr;

    logic [7:0] idx8;
    logic       accept;
    logic       key_wr;
    logic       iv_wr;
    logic [7:0] kl;
    logic [7:0] vl;
    logic [7:0] q_inc;
    logic [7:0] e_byte;
    logic [7:0] j_sched;
    logic [7:0] j_ciph;
    logic       out_free;

    assign idx8     = {2'b00, index};
    assign accept   = (cmd == rc4ms_pkg::CMD_ACCEPT);
    assign key_wr   = accept && (op == rc4ms_pkg::OP_KEY) && (idx8 < KEY_MAX_8);
    assign iv_wr    = accept && (op == rc4ms_pkg::OP_IV) && (idx8 < IV_MAX_8);
    assign out_free = !out_valid_reg || !out_stall;

    // Effective lengths: zero key length counts as one, both saturate
    always_comb
    begin
        if (key_len_reg == '0)
        begin
            kl = 8'd1;
        end
        else if ({1'b0, key_len_reg} > KEY_MAX_8)
        begin
            kl = KEY_MAX_8;
        end
        else
        begin
            kl = {1'b0, key_len_reg};
        end
        vl = ({1'b0, iv_len_reg} > IV_MAX_8) ? IV_MAX_8 : {1'b0, iv_len_reg};
    end

    assign e_byte  = esel_reg ? iv_rd_reg : key_rd_reg;
    assign j_sched = j_reg + perm_rd_reg + e_byte;
    assign j_ciph  = j_reg + perm_rd_reg;
    assign q_inc   = q_reg + 8'd1;

    // Advance the expanded key pointer: key, then IV, then key repeated
    always_comb
    begin
        q_next     = q_inc;
        phase_next = phase_reg;
        case (phase_reg)
            rc4ms_pkg::PH_KEY:
            begin
                if (q_inc == kl)
                begin
                    q_next     = '0;
                    phase_next = (vl == '0) ? rc4ms_pkg::PH_REP : rc4ms_pkg::PH_IV;
                end
            end
            rc4ms_pkg::PH_IV:
            begin
                if (q_inc == vl)
                begin
                    q_next     = '0;
                    phase_next = rc4ms_pkg::PH_REP;
                end
            end
            default:
            begin
                if (q_inc == kl)
                begin
                    q_next = '0;
                end
            end
        endcase
        if (p_reg == 8'hFF)
        begin
            q_next     = '0;
            phase_next = rc4ms_pkg::PH_KEY;
        end
    end

    // Permutation table port selection
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = p_reg;
        mem_wdata = perm_rd_reg;
        mem_re    = 1'b0;
        mem_raddr = p_reg;
        unique case (cmd)
            rc4ms_pkg::CMD_FILL:
            begin
                mem_we    = 1'b1;
                mem_wdata = p_reg;
            end
            rc4ms_pkg::CMD_SA:
            begin
                mem_re = 1'b1;
            end
            rc4ms_pkg::CMD_SB:
            begin
                mem_re    = 1'b1;
                mem_raddr = j_sched;
            end
            rc4ms_pkg::CMD_SC:
            begin
                mem_we = 1'b1;
            end
            rc4ms_pkg::CMD_SD:
            begin
                mem_we    = 1'b1;
                mem_waddr = j_reg;
                mem_wdata = swap_a_reg;
            end
            rc4ms_pkg::CMD_C1:
            begin
                mem_re    = 1'b1;
                mem_raddr = i_reg + 8'd1;
            end
            rc4ms_pkg::CMD_C2:
            begin
                mem_re    = 1'b1;
                mem_raddr = j_ciph;
            end
            rc4ms_pkg::CMD_C3:
            begin
                mem_we    = 1'b1;
                mem_waddr = i_reg;
            end
            rc4ms_pkg::CMD_C4:
            begin
                mem_we    = 1'b1;
                mem_waddr = j_reg;
                mem_wdata = swap_a_reg;
            end
            rc4ms_pkg::CMD_C5:
            begin
                mem_re    = 1'b1;
                mem_raddr = swap_a_reg + swap_b_reg;
            end
            default:
            begin
                mem_we = 1'b0;
                mem_re = 1'b0;
            end
        endcase
    end

    // Permutation table
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            perm_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            perm_rd_reg <= perm_mem[mem_raddr];
        end
    end

    // Key and IV stores, read together at the start of a schedule step
    always_ff @(posedge clk)
    begin
        if (key_wr)
        begin
            key_mem[idx8[KA_W-1:0]] <= value;
        end
        if (cmd == rc4ms_pkg::CMD_SA)
        begin
            key_rd_reg <= key_mem[q_reg[KA_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (iv_wr)
        begin
            iv_mem[idx8[VA_W-1:0]] <= value;
        end
        if (cmd == rc4ms_pkg::CMD_SA)
        begin
            iv_rd_reg <= iv_mem[q_reg[VA_W-1:0]];
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_len_reg <= rc4ms_pkg::KEY_LEN_RST;
            iv_len_reg  <= rc4ms_pkg::IV_LEN_RST;
            rounds_reg  <= rc4ms_pkg::ROUNDS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rc4ms_pkg::CFG_KEY_LEN: key_len_reg <= cfg_data[rc4ms_pkg::LEN_W-1:0];
                rc4ms_pkg::CFG_IV_LEN:  iv_len_reg  <= cfg_data[rc4ms_pkg::LEN_W-1:0];
                rc4ms_pkg::CFG_ROUNDS:  rounds_reg  <= cfg_data;
                default:                rounds_reg  <= rounds_reg;
            endcase
        end
    end

    // Schedule and cipher control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg  <= 1'b0;
            p_reg     <= '0;
            rnd_reg   <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            q_reg     <= '0;
            phase_reg <= rc4ms_pkg::PH_KEY;
            esel_reg  <= 1'b0;
        end
        else
        begin
            unique case (cmd)
                rc4ms_pkg::CMD_ACCEPT:
                begin
                    if (op == rc4ms_pkg::OP_KEY || op == rc4ms_pkg::OP_IV)
                    begin
                        done_reg <= 1'b0;
                    end
                end
                rc4ms_pkg::CMD_INIT:
                begin
                    p_reg     <= '0;
                    rnd_reg   <= '0;
                    j_reg     <= '0;
                    q_reg     <= '0;
                    phase_reg <= rc4ms_pkg::PH_KEY;
                end
                rc4ms_pkg::CMD_FILL:
                begin
                    p_reg <= p_reg + 8'd1;
                end
                rc4ms_pkg::CMD_SA:
                begin
                    esel_reg <= (phase_reg == rc4ms_pkg::PH_IV);
                end
                rc4ms_pkg::CMD_SB:
                begin
                    j_reg <= j_sched;
                end
                rc4ms_pkg::CMD_SD:
                begin
                    p_reg     <= p_reg + 8'd1;
                    q_reg     <= q_next;
                    phase_reg <= phase_next;
                    if (p_reg == 8'hFF)
                    begin
                        rnd_reg <= rnd_reg + 8'd1;
                    end
                end
                rc4ms_pkg::CMD_SEND:
                begin
                    i_reg    <= '0;
                    j_reg    <= '0;
                    done_reg <= 1'b1;
                end
                rc4ms_pkg::CMD_C1:
                begin
                    i_reg <= i_reg + 8'd1;
                end
                rc4ms_pkg::CMD_C2:
                begin
                    j_reg <= j_ciph;
                end
                default:
                begin
                    done_reg <= done_reg;
                end
            endcase
        end
    end

    // Swap operands and the data byte
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            val_reg <= value;
        end
        if (cmd == rc4ms_pkg::CMD_SB || cmd == rc4ms_pkg::CMD_C2)
        begin
            swap_a_reg <= perm_rd_reg;
        end
        if (cmd == rc4ms_pkg::CMD_C3)
        begin
            swap_b_reg <= perm_rd_reg;
        end
    end

    // Output register: load on the keystream byte, drop when the beat is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd == rc4ms_pkg::CMD_OUT && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd == rc4ms_pkg::CMD_OUT && out_free)
        begin
            out_byte_reg <= val_reg ^ perm_rd_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;

    // Status for the controller
    assign sts.done        = done_reg;
    assign sts.p_last      = (p_reg == 8'hFF);
    assign sts.round_last  = (({1'b0, rnd_reg} + 9'd1) == {1'b0, rounds_reg});
    assign sts.rounds_zero = (rounds_reg == '0);
    assign sts.out_free    = out_free;

endmodule

// File: tb/tb_rc4_multi_round_stream_cipher.sv
module tb_rc4_multi_round_stream_cipher;
    timeunit 1ns;
    timeprecision 1ps;

    // Codes the package leaves unnamed
    localparam logic [rc4ms_pkg::OP_W-1:0]      OP_UNUSED = 2'd3;
    localparam logic [rc4ms_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam int RANDOM_ITEMS = 1150;
    localparam int PHASE_ITEMS  = 100;
    localparam int SETTLE_CYCLES = 32;

    // Keeps its own copy of the cipher state and holds the bytes still due
    class cipher_scoreboard;
        logic [rc4ms_pkg::LEN_W-1:0]  key_len_reg;
        logic [rc4ms_pkg::LEN_W-1:0]  iv_len_reg;
        logic [rc4ms_pkg::BYTE_W-1:0] rounds_reg;
        logic [rc4ms_pkg::BYTE_W-1:0] key_bytes [rc4ms_pkg::KEY_MAX_DEF];
        logic [rc4ms_pkg::BYTE_W-1:0] iv_bytes [rc4ms_pkg::IV_MAX_DEF];
        logic [rc4ms_pkg::BYTE_W-1:0] sbox [256];
        logic [rc4ms_pkg::BYTE_W-1:0] ptr_i;
        logic [rc4ms_pkg::BYTE_W-1:0] ptr_j;
        bit                           keyed;
        logic [rc4ms_pkg::BYTE_W-1:0] cipher_bytes_due [$];
        int                           errors;
        int                           checked;
        int                           schedules;
        int                           beats;

        function new();
            key_len_reg = rc4ms_pkg::KEY_LEN_RST;
            iv_len_reg  = rc4ms_pkg::IV_LEN_RST;
            rounds_reg  = rc4ms_pkg::ROUNDS_RST;
            ptr_i       = '0;
            ptr_j       = '0;
            keyed       = 1'b0;
            errors      = 0;
            checked     = 0;
            schedules   = 0;
            beats       = 0;
        endfunction

        function void write_register(logic [rc4ms_pkg::CFG_IDX_W-1:0] idx,
                                     logic [rc4ms_pkg::BYTE_W-1:0] data);
            case (idx)
                rc4ms_pkg::CFG_KEY_LEN: key_len_reg = data[rc4ms_pkg::LEN_W-1:0];
                rc4ms_pkg::CFG_IV_LEN:  iv_len_reg  = data[rc4ms_pkg::LEN_W-1:0];
                rc4ms_pkg::CFG_ROUNDS:  rounds_reg  = data;
                default:                ;
            endcase
        endfunction

        // Expand key and IV to 256 bytes, then run the key schedule for all rounds
        function void run_schedule();
            logic [rc4ms_pkg::BYTE_W-1:0] expanded [256];
            logic [rc4ms_pkg::BYTE_W-1:0] j;
            logic [rc4ms_pkg::BYTE_W-1:0] t;
            int                           kl;
            int                           vl;
            kl = key_len_reg;
            vl = iv_len_reg;
            if (kl == 0)
                kl = 1;
            if (kl > rc4ms_pkg::KEY_MAX_DEF)
                kl = rc4ms_pkg::KEY_MAX_DEF;
            if (vl > rc4ms_pkg::IV_MAX_DEF)
                vl = rc4ms_pkg::IV_MAX_DEF;
            for (int p = 0; p < 256; p++)
            begin
                if (p < kl)
                    expanded[p] = key_bytes[p];
                else if (p < kl + vl)
                    expanded[p] = iv_bytes[p - kl];
                else
                    expanded[p] = key_bytes[(p - kl - vl) % kl];
                sbox[p] = 8'(p);
            end
            // j carries over from one round to the next
            j = '0;
            for (int n = 0; n < rounds_reg; n++)
            begin
                for (int p = 0; p < 256; p++)
                begin
                    j       = j + sbox[p] + expanded[p];
                    t       = sbox[p];
                    sbox[p] = sbox[j];
                    sbox[j] = t;
                end
            end
            ptr_i = '0;
            ptr_j = '0;
            keyed = 1'b1;
            schedules++;
        endfunction

        function logic [rc4ms_pkg::BYTE_W-1:0] encrypt_byte(logic [rc4ms_pkg::BYTE_W-1:0] val);
            logic [rc4ms_pkg::BYTE_W-1:0] t;
            logic [rc4ms_pkg::BYTE_W-1:0] k;
            if (!keyed)
                run_schedule();
            ptr_i       = ptr_i + 8'd1;
            ptr_j       = ptr_j + sbox[ptr_i];
            t           = sbox[ptr_i];
            sbox[ptr_i] = sbox[ptr_j];
            sbox[ptr_j] = t;
            k           = sbox[ptr_i] + sbox[ptr_j];
            return val ^ sbox[k];
        endfunction

        function void note_beat(logic [rc4ms_pkg::OP_W-1:0] op,
                                logic [rc4ms_pkg::INDEX_W-1:0] idx,
                                logic [rc4ms_pkg::BYTE_W-1:0] val);
            beats++;
            case (op)
                rc4ms_pkg::OP_KEY:
                begin
                    key_bytes[idx] = val;
                    keyed          = 1'b0;
                end
                rc4ms_pkg::OP_IV:
                begin
                    iv_bytes[idx] = val;
                    keyed         = 1'b0;
                end
                rc4ms_pkg::OP_DATA: cipher_bytes_due.push_back(encrypt_byte(val));
                default: ;
            endcase
        endfunction

        function void check_out_byte(logic [rc4ms_pkg::BYTE_W-1:0] got);
            logic [rc4ms_pkg::BYTE_W-1:0] want;
            if (cipher_bytes_due.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("[%0t] output byte %02h with nothing expected", $realtime, got);
            end
            else
            begin
                want = cipher_bytes_due.pop_front();
                checked++;
                if (got !== want)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("[%0t] out_byte mismatch: expected %02h, got %02h",
                                 $realtime, want, got);
                end
            end
        endfunction
    endclass

    logic                            clk        = 1'b0;
    logic                            rst_n      = 1'b0;
    logic                            in_valid   = 1'b0;
    logic                            in_stall;
    logic [rc4ms_pkg::OP_W-1:0]      item_op    = rc4ms_pkg::OP_KEY;
    logic [rc4ms_pkg::INDEX_W-1:0]   item_index = '0;
    logic [rc4ms_pkg::BYTE_W-1:0]    item_value = '0;
    logic                            out_valid;
    logic                            out_stall  = 1'b0;
    logic [rc4ms_pkg::BYTE_W-1:0]    out_byte;
    logic                            cfg_we     = 1'b0;
    logic [rc4ms_pkg::CFG_IDX_W-1:0] cfg_index  = rc4ms_pkg::CFG_KEY_LEN;
    logic [rc4ms_pkg::BYTE_W-1:0]    cfg_data   = '0;

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int hold_cnt     = 0;
    int stim_items   = 0;

    cipher_scoreboard sb = new();

    rc4_multi_round_stream_cipher dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (item_op),
        .index     (item_index),
        .value     (item_value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Stall the output at random, or hold it off for a counted stretch
    always @(posedge clk)
    begin
        if (hold_cnt > 0)
        begin
            out_stall <= 1'b1;
            hold_cnt = hold_cnt - 1;
        end
        else
            out_stall <= ($urandom_range(99) < rx_stall_pct);
    end

    // Check output beats, then record input beats
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_out_byte(out_byte);
            if (in_valid && !in_stall)
                sb.note_beat(item_op, item_index, item_value);
        end
    end

    // Offer one beat after an optional idle gap and wait until it is taken
    task automatic send_beat(input logic [rc4ms_pkg::OP_W-1:0] o,
                             input logic [rc4ms_pkg::INDEX_W-1:0] ix,
                             input logic [rc4ms_pkg::BYTE_W-1:0] v);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        item_op    <= o;
        item_index <= ix;
        item_value <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (o != OP_UNUSED)
            stim_items++;
    endtask

    // Stop offering and wait until every cipher byte has come out
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.cipher_bytes_due.size() != 0)
            @(posedge clk);
    endtask

    // Drain, then give trailing store writes time to finish
    task automatic settle();
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(input logic [rc4ms_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rc4ms_pkg::BYTE_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_register(idx, data);
    endtask

    // Write all registers, plus the unused index, which must have no effect
    task automatic configure(input logic [rc4ms_pkg::BYTE_W-1:0] kl,
                             input logic [rc4ms_pkg::BYTE_W-1:0] vl,
                             input logic [rc4ms_pkg::BYTE_W-1:0] rn);
        put_reg(rc4ms_pkg::CFG_KEY_LEN, kl);
        put_reg(rc4ms_pkg::CFG_IV_LEN, vl);
        put_reg(rc4ms_pkg::CFG_ROUNDS, rn);
        put_reg(CFG_SPARE, 8'($urandom_range(255)));
        cfg_we <= 1'b0;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0:
            begin
                tx_idle_pct  = 0;
                rx_stall_pct = 0;
            end
            1:
            begin
                tx_idle_pct  = 69;
                rx_stall_pct = 0;
            end
            2:
            begin
                tx_idle_pct  = 0;
                rx_stall_pct = 69;
            end
            default:
            begin
                tx_idle_pct  = 25;
                rx_stall_pct = 25;
            end
        endcase
    endtask

    // A few key or IV writes with some noise, then a burst of data beats
    task automatic rekey_and_stream();
        int n_writes;
        int n_data;
        n_writes = ($urandom_range(4) == 0) ? 0 : $urandom_range(1, 4);
        n_data   = ($urandom_range(7) == 0) ? 0 : $urandom_range(10, 40);
        repeat (n_writes)
        begin
            if ($urandom_range(9) == 0)
                send_beat(OP_UNUSED, 6'($urandom_range(63)), 8'($urandom_range(255)));
            send_beat($urandom_range(1) ? rc4ms_pkg::OP_IV : rc4ms_pkg::OP_KEY,
                      6'($urandom_range(63)), 8'($urandom_range(255)));
        end
        repeat (n_data)
        begin
            if ($urandom_range(19) == 0)
                send_beat(OP_UNUSED, 6'($urandom_range(63)), 8'($urandom_range(255)));
            send_beat(rc4ms_pkg::OP_DATA, 6'($urandom_range(63)), 8'($urandom_range(255)));
        end
    endtask

    initial
    begin
        logic [rc4ms_pkg::BYTE_W-1:0] kl;
        logic [rc4ms_pkg::BYTE_W-1:0] vl;
        logic [rc4ms_pkg::BYTE_W-1:0] rn;
        int                           phase;
        int                           phase_start;
        int                           seq;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill both stores so no unwritten entry is ever read
        for (int k = 0; k < rc4ms_pkg::KEY_MAX_DEF; k++)
            send_beat(rc4ms_pkg::OP_KEY, 6'(k), 8'($urandom_range(255)));
        for (int k = 0; k < rc4ms_pkg::IV_MAX_DEF; k++)
            send_beat(rc4ms_pkg::OP_IV, 6'(k), 8'($urandom_range(255)));

        // Reset settings: first data beat builds the schedule; unused op is dropped
        send_beat(rc4ms_pkg::OP_DATA, 6'd0, 8'h00);
        send_beat(rc4ms_pkg::OP_DATA, 6'd63, 8'hFF);
        send_beat(OP_UNUSED, 6'd63, 8'hFF);
        send_beat(rc4ms_pkg::OP_DATA, 6'h2A, 8'hA5);
        settle();

        // Zero key length, no IV, zero rounds; store edges
        configure(8'd0, 8'd0, 8'd0);
        send_beat(rc4ms_pkg::OP_KEY, 6'd0, 8'h00);
        send_beat(rc4ms_pkg::OP_KEY, 6'd63, 8'hFF);
        send_beat(rc4ms_pkg::OP_IV, 6'd0, 8'hFF);
        send_beat(rc4ms_pkg::OP_IV, 6'd63, 8'h00);
        send_beat(rc4ms_pkg::OP_DATA, 6'd0, 8'h3C);
        send_beat(rc4ms_pkg::OP_DATA, 6'd63, 8'hC3);
        settle();

        // Lengths beyond the stores saturate; single round
        configure(8'hFF, 8'hFF, 8'd1);
        send_beat(rc4ms_pkg::OP_KEY, 6'd17, 8'($urandom_range(255)));
        repeat (3)
            send_beat(rc4ms_pkg::OP_DATA, 6'($urandom_range(63)), 8'($urandom_range(255)));
        settle();

        // Full key and IV, most rounds
        configure(8'd64, 8'd64, 8'd255);
        send_beat(rc4ms_pkg::OP_IV, 6'd1, 8'($urandom_range(255)));
        repeat (2)
            send_beat(rc4ms_pkg::OP_DATA, 6'($urandom_range(63)), 8'($urandom_range(255)));

        // Hold the output off while data keeps coming, so the input backs up
        stim_items = 0;
        set_idling(0);
        hold_cnt = 300;
        repeat (8)
            send_beat(rc4ms_pkg::OP_DATA, 6'($urandom_range(63)), 8'($urandom_range(255)));

        // Random phases, each with its own settings and idling mix
        phase = 0;
        while (stim_items < RANDOM_ITEMS)
        begin
            settle();
            case ($urandom_range(5))
                0:       kl = 8'd1;
                1:       kl = 8'(rc4ms_pkg::KEY_MAX_DEF);
                2:       kl = 8'($urandom_range(65, 255));
                3:       kl = 8'd0;
                default: kl = 8'($urandom_range(1, 64));
            endcase
            case ($urandom_range(4))
                0:       vl = 8'd0;
                1:       vl = 8'(rc4ms_pkg::IV_MAX_DEF);
                2:       vl = 8'($urandom_range(65, 255));
                default: vl = 8'($urandom_range(0, 64));
            endcase
            if (phase % 5 == 4)
                rn = 8'($urandom_range(4, 12));
            else if ($urandom_range(9) == 0)
                rn = 8'd0;
            else
                rn = 8'($urandom_range(1, 3));
            configure(kl, vl, rn);
            set_idling(phase % 4);

            phase_start = stim_items;
            seq         = 0;
            while (stim_items - phase_start < PHASE_ITEMS && stim_items < RANDOM_ITEMS)
            begin
                rekey_and_stream();
                seq++;
                // Pause the sender until the block has emptied
                if (seq == 2)
                    drain();
            end
            phase++;
        end

        drain();
        repeat (40) @(posedge clk);

        $display("Run: %0d beats in, %0d cipher bytes checked, %0d key schedules, %0d errors.",
                 sb.beats, sb.checked, sb.schedules, sb.errors);
        $display("Settings: key length 0..127, IV length 0..127, rounds 0..255, %0d phases.",
                 phase + 4);
        if (sb.errors == 0 && sb.cipher_bytes_due.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog
    initial
    begin
        #100_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
